[hw/rtl/rre_pkg.sv]
// Shared constants and control/status types for the radix range encoder.
// Used by rre_ctrl, rre_dp and radix_range_encoder_top; depends on nothing.
`default_nettype none

package rre_pkg;

    localparam int EMIT_SHIFT = 48;
    localparam int IV_W       = EMIT_SHIFT + 8;
    localparam int CALC_W     = 64;
    localparam int RADIX_W    = 9;
    localparam int DIGIT_W    = 8;
    localparam int REM_W      = 8;
    localparam int STEP_W     = $clog2(CALC_W);
    localparam int CNT_W      = 3;
    localparam int GUARD_W    = 13;
    localparam int END_BYTES  = (EMIT_SHIFT + 15) / 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(58);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_PASS  = RADIX_W'(256);
    localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(CALC_W - 1);
    localparam logic [CNT_W-1:0]   MAX_OUT     = CNT_W'(7);
    localparam logic [CNT_W-1:0]   FINAL_CNT   = CNT_W'(END_BYTES - 1);
    localparam logic [GUARD_W-1:0] PHANTOM_LIM = GUARD_W'(4096);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic clear_state;
        logic use_phantom;
        logic do_mul;
        logic div_init;
        logic div_step;
        logic update;
        logic shift;
        logic push_err;
        logic push_pass;
        logic push_byte;
        logic push_final;
    } rre_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reject;
        logic passthru;
        logic renorm_need;
        logic out_free;
    } rre_sts_t;

endpackage

`default_nettype wire

[hw/rtl/radix_range_encoder_top.sv]
// Sequence: once a coded digit is accepted, the interval is narrowed (check, multiply,
// divider load, 64 divide steps, update); renormalisation then emits bytes, waiting while
// the output register is occupied, until none is needed or the final byte ends the message.
// The next word is taken only once the previous one is done; after the last word, phantom
// digits flush the interval, and passthrough and invalid digits skip the narrowing.
// Reset (rst_n, asynchronous, active low) sets radix 58 and the full interval span.
`default_nettype none

module radix_range_encoder_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // Configuration: radix register, written whenever cfg_we is high.
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata,

    // Input words.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] digit
    input  wire logic       s_axis_tuser,   // [0] bad_symbol
    input  wire logic       s_axis_tlast,   // end_of_message

    // Output words.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] error
    output logic            m_axis_tlast    // final_byte
);

    rre_pkg::rre_cmd_t cmd;
    rre_pkg::rre_sts_t sts;

    // The controller accepts a word only when idle. The output register in the
    // datapath decouples the two sides, so a new word is taken while the previous
    // result still waits for the downstream side.
    rre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the radix, the interval bounds, the multiplier, the
    // pair of dividers that form both ceiling quotients at once, and the output
    // register. A radix write also returns the interval to its reset span.
    rre_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_digit  (s_axis_tdata),
        .in_bad    (s_axis_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata),
        .out_final (m_axis_tlast),
        .out_error (m_axis_tuser)
    );

endmodule

`default_nettype wire

[hw/rtl/rre_dp.sv]
// Datapath of the radix range encoder: radix register, interval bounds,
// multiplier, twin restoring divider, renormalisation and output register.
// Depends on rre_pkg.
`default_nettype none

module rre_dp
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rre_pkg::RADIX_W-1:0]       cfg_wdata,
    input  wire logic [rre_pkg::DIGIT_W-1:0]       in_digit,
    input  wire logic                              in_bad,
    input  wire rre_pkg::rre_cmd_t                 cmd,
    output rre_pkg::rre_sts_t                      sts,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [7:0]                             out_byte,
    output logic                                   out_final,
    output logic                                   out_error
);

    logic [rre_pkg::RADIX_W-1:0] radix_reg;
    logic [rre_pkg::RADIX_W-1:0] m_eff;
    logic [rre_pkg::DIGIT_W-1:0] digit_reg;
    logic                        bad_reg;
    logic [rre_pkg::IV_W-1:0]    low_reg;
    logic [rre_pkg::IV_W-1:0]    low_next;
    logic [rre_pkg::IV_W-1:0]    high_reg;
    logic [rre_pkg::IV_W-1:0]    high_next;
    logic [rre_pkg::CALC_W-1:0]  range_w;
    logic [rre_pkg::CALC_W-1:0]  prod_w;
    logic [rre_pkg::CALC_W-1:0]  prod_reg;
    logic [rre_pkg::CALC_W-1:0]  d_reg;
    logic [rre_pkg::CALC_W-1:0]  m_m1;
    logic [rre_pkg::CALC_W-1:0]  num_lo_reg;
    logic [rre_pkg::CALC_W-1:0]  num_hi_reg;
    logic [rre_pkg::REM_W-1:0]   rem_lo_reg;
    logic [rre_pkg::REM_W-1:0]   rem_hi_reg;
    logic [rre_pkg::REM_W:0]     trial_lo;
    logic [rre_pkg::REM_W:0]     trial_hi;
    logic                        qbit_lo;
    logic                        qbit_hi;
    logic [rre_pkg::DIGIT_W-1:0] c_sel;
    logic                        agree;
    logic                        tight;
    logic                        out_valid_reg;
    logic [7:0]                  out_byte_reg;
    logic                        out_final_reg;
    logic                        out_error_reg;

    // Radix clamped into its legal range.
    always_comb
    begin
        priority if (radix_reg < rre_pkg::RADIX_MIN)
        begin
            m_eff = rre_pkg::RADIX_MIN;
        end
        else if (radix_reg > rre_pkg::RADIX_PASS)
        begin
            m_eff = rre_pkg::RADIX_PASS;
        end
        else
        begin
            m_eff = radix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rre_pkg::RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            digit_reg <= in_digit;
            bad_reg   <= in_bad;
        end
    end

    // Phantom digits sit at the middle of the alphabet.
    assign c_sel   = cmd.use_phantom ? m_eff[rre_pkg::RADIX_W-1:1] : digit_reg;
    assign range_w = rre_pkg::CALC_W'(high_reg) - rre_pkg::CALC_W'(low_reg)
                     + rre_pkg::CALC_W'(1);
    assign prod_w  = range_w * rre_pkg::CALC_W'(c_sel);
    assign m_m1    = rre_pkg::CALC_W'(m_eff) - rre_pkg::CALC_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.do_mul)
        begin
            prod_reg <= prod_w;
            d_reg    <= range_w;
        end
    end

    // Two restoring dividers run side by side, one quotient bit each per cycle.
    assign trial_lo = {rem_lo_reg, num_lo_reg[rre_pkg::CALC_W-1]};
    assign trial_hi = {rem_hi_reg, num_hi_reg[rre_pkg::CALC_W-1]};
    assign qbit_lo  = (trial_lo >= m_eff);
    assign qbit_hi  = (trial_hi >= m_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            num_lo_reg <= prod_reg + m_m1;
            num_hi_reg <= prod_reg + d_reg + m_m1;
            rem_lo_reg <= '0;
            rem_hi_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_lo_reg <= {num_lo_reg[rre_pkg::CALC_W-2:0], qbit_lo};
            num_hi_reg <= {num_hi_reg[rre_pkg::CALC_W-2:0], qbit_hi};
            rem_lo_reg <= qbit_lo ? rre_pkg::REM_W'(trial_lo - m_eff)
                                  : trial_lo[rre_pkg::REM_W-1:0];
            rem_hi_reg <= qbit_hi ? rre_pkg::REM_W'(trial_hi - m_eff)
                                  : trial_hi[rre_pkg::REM_W-1:0];
        end
    end

    // Interval bounds.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        priority if (cfg_we || cmd.clear_state)
        begin
            low_next  = '0;
            high_next = '1;
        end
        else if (cmd.update)
        begin
            low_next  = low_reg + num_lo_reg[rre_pkg::IV_W-1:0];
            high_next = low_reg + num_hi_reg[rre_pkg::IV_W-1:0]
                        - rre_pkg::IV_W'(1);
        end
        else if (cmd.shift)
        begin
            low_next  = {low_reg[rre_pkg::EMIT_SHIFT-1:0], 8'h00};
            high_next = {high_reg[rre_pkg::EMIT_SHIFT-1:0], 8'hFF};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '1;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign agree = (high_reg[rre_pkg::IV_W-1:rre_pkg::EMIT_SHIFT]
                    == low_reg[rre_pkg::IV_W-1:rre_pkg::EMIT_SHIFT]);
    assign tight = ({1'b0, high_reg}
                    < ({1'b0, low_reg} + (rre_pkg::IV_W + 1)'(m_eff)
                       - (rre_pkg::IV_W + 1)'(1)));

    assign sts.reject      = bad_reg || (rre_pkg::RADIX_W'(digit_reg) >= m_eff);
    assign sts.passthru    = (m_eff == rre_pkg::RADIX_PASS);
    assign sts.renorm_need = agree || tight;
    assign sts.out_free    = !out_valid_reg || out_ready;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_err || cmd.push_pass || cmd.push_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.push_err)
        begin
            out_byte_reg  <= 8'h00;
            out_final_reg <= 1'b0;
            out_error_reg <= 1'b1;
        end
        else if (cmd.push_pass)
        begin
            out_byte_reg  <= digit_reg;
            out_final_reg <= cmd.push_final;
            out_error_reg <= 1'b0;
        end
        else if (cmd.push_byte)
        begin
            out_byte_reg  <= low_reg[rre_pkg::IV_W-1:rre_pkg::EMIT_SHIFT];
            out_final_reg <= cmd.push_final;
            out_error_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_final = out_final_reg;
    assign out_error = out_error_reg;

endmodule

`default_nettype wire

[hw/rtl/rre_ctrl.sv]
// Controller of the radix range encoder: sequences check, narrowing,
// division steps, renormalisation and the phantom-digit tail. Depends on rre_pkg.
`default_nettype none

module rre_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    output logic                   in_ready,
    input  wire rre_pkg::rre_sts_t sts,
    output rre_pkg::rre_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DINIT  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_RENORM = 3'd6;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [rre_pkg::STEP_W-1:0]  step_reg;
    logic [rre_pkg::STEP_W-1:0]  step_next;
    logic [rre_pkg::CNT_W-1:0]   cnt_reg;
    logic [rre_pkg::CNT_W-1:0]   cnt_next;
    logic [rre_pkg::GUARD_W-1:0] guard_reg;
    logic [rre_pkg::GUARD_W-1:0] guard_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        phantom_reg;
    logic                        phantom_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        guard_next   = guard_reg;
        last_next    = last_reg;
        phantom_next = phantom_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        cmd.use_phantom = phantom_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in  = 1'b1;
                    last_next    = in_last;
                    cnt_next     = '0;
                    guard_next   = '0;
                    phantom_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.reject)
                begin
                    if (sts.out_free)
                    begin
                        cmd.push_err    = 1'b1;
                        cmd.clear_state = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (sts.passthru)
                begin
                    if (sts.out_free)
                    begin
                        cmd.push_pass  = 1'b1;
                        cmd.push_final = last_reg;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + rre_pkg::STEP_W'(1);
                if (step_reg == rre_pkg::DIV_LAST)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_RENORM;
            end
            S_RENORM:
            begin
                if (sts.renorm_need && (cnt_reg != rre_pkg::MAX_OUT))
                begin
                    if (sts.out_free)
                    begin
                        cmd.push_byte = 1'b1;
                        cnt_next      = cnt_reg + rre_pkg::CNT_W'(1);
                        if (last_reg && (cnt_reg == rre_pkg::FINAL_CNT))
                        begin
                            // Seventh byte after the end closes the message.
                            cmd.push_final  = 1'b1;
                            cmd.clear_state = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.shift = 1'b1;
                        end
                    end
                end
                else if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (guard_reg == rre_pkg::PHANTOM_LIM)
                begin
                    cmd.clear_state = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    guard_next   = guard_reg + rre_pkg::GUARD_W'(1);
                    phantom_next = 1'b1;
                    state_next   = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            guard_reg   <= '0;
            last_reg    <= 1'b0;
            phantom_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            guard_reg   <= guard_next;
            last_reg    <= last_next;
            phantom_reg <= phantom_next;
        end
    end

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_err || cmd.push_pass || cmd.push_byte) |-> sts.out_free)
        else $error("Result pushed while the output register was still occupied.");

    a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push_err, cmd.push_pass, cmd.push_byte}))
        else $error("More than one kind of result pushed in one cycle.");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_final |-> (last_reg && (cmd.push_pass || cmd.push_byte)))
        else $error("Final flag raised outside the last word of a message.");

    a_byte_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_byte |-> (cnt_reg != rre_pkg::MAX_OUT))
        else $error("More bytes sent for one digit than allowed.");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == rre_pkg::DIV_LAST) |=> (state_reg == S_UPD))
        else $error("Divider did not hand over to the interval update.");

endmodule

`default_nettype wire
